>>> rtl/lrup_pkg.sv
// Package for the LRU page frame manager: sizes, operation codes and the
// structs passed between the top level and the frame cells.
// No dependencies.
package lrup_pkg;

  // Frame count and stored page width.
  localparam int unsigned FRAMES    = 8;
  localparam int unsigned PAGE_BITS = 16;

  // Derived widths.
  localparam int unsigned IDX_W   = $clog2(FRAMES);
  localparam int unsigned RANK_W  = $clog2(FRAMES);
  localparam int unsigned CNT_W   = $clog2(FRAMES + 1);
  localparam int unsigned FAULT_W = 16;
  localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

  // Port field widths.
  localparam int unsigned IN_PAGE_W = 16;
  localparam int unsigned OUT_IDX_W = 3;

  // What the frame chain does with the current reference.
  typedef enum logic [1:0] {
    OP_HIT,
    OP_FILL,
    OP_EVICT
  } op_e;

  // Command broadcast from the top level to every cell.
  typedef struct packed {
    logic                 en;
    op_e                  op;
    logic [PAGE_BITS-1:0] page;
    logic [RANK_W-1:0]    old_rank;
    logic [RANK_W-1:0]    new_rank;
  } cmd_t;

  // Search word handed from one cell to the next.
  typedef struct packed {
    logic                 hit;
    logic [IDX_W-1:0]     hit_idx;
    logic [RANK_W-1:0]    hit_rank;
    logic                 free;
    logic [IDX_W-1:0]     free_idx;
    logic                 vic;
    logic [IDX_W-1:0]     vic_idx;
    logic [PAGE_BITS-1:0] vic_page;
  } chain_t;

  // Per-cell status for checking.
  typedef struct packed {
    logic valid;
    logic match;
    logic vic;
  } stat_t;

  // Fit an input page number to the stored page width.
  function automatic logic [PAGE_BITS-1:0] to_page(input logic [IN_PAGE_W-1:0] p);
    logic [PAGE_BITS+IN_PAGE_W-1:0] t;
    t = {{PAGE_BITS{1'b0}}, p};
    return t[PAGE_BITS-1:0];
  endfunction

  // Fit a stored page number to the output field width.
  function automatic logic [IN_PAGE_W-1:0] from_page(input logic [PAGE_BITS-1:0] p);
    logic [PAGE_BITS+IN_PAGE_W-1:0] t;
    t = {{IN_PAGE_W{1'b0}}, p};
    return t[IN_PAGE_W-1:0];
  endfunction

  // Fit a frame index to the output field width.
  function automatic logic [OUT_IDX_W-1:0] to_out_idx(input logic [IDX_W-1:0] i);
    logic [IDX_W+OUT_IDX_W-1:0] t;
    t = {{OUT_IDX_W{1'b0}}, i};
    return t[OUT_IDX_W-1:0];
  endfunction

endpackage

>>> rtl/lrup_if.sv
// Handshake interfaces for the page reference word and the result word.
// Depends on lrup_pkg for the field widths.
interface lrup_in_if;
  logic                           valid;
  logic                           ready;
  logic [lrup_pkg::IN_PAGE_W-1:0] vpn;

  modport source (output valid, output vpn, input ready);
  modport sink   (input valid, input vpn, output ready);
endinterface

interface lrup_out_if;
  logic                           valid;
  logic                           ready;
  logic                           hit;
  logic [lrup_pkg::OUT_IDX_W-1:0] frame_index;
  logic                           evicted_valid;
  logic [lrup_pkg::IN_PAGE_W-1:0] evicted_page;
  logic [lrup_pkg::FAULT_W-1:0]   fault_total;

  modport source (output valid, output hit, output frame_index, output evicted_valid,
                  output evicted_page, output fault_total, input ready);
  modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                  input evicted_page, input fault_total, output ready);
endinterface

>>> rtl/lrup_cell.sv
// One page frame: stored page, valid bit and recency rank, with its stage of
// the search chain. Depends on lrup_pkg.
module lrup_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [lrup_pkg::IDX_W-1:0] idx_i,
  input  lrup_pkg::cmd_t           cmd_i,
  input  lrup_pkg::chain_t         chain_i,
  output lrup_pkg::chain_t         chain_o,
  output lrup_pkg::stat_t          stat_o
);
  import lrup_pkg::*;

  logic [PAGE_BITS-1:0] page_q;
  logic                 valid_q;
  logic [RANK_W-1:0]    rank_q, rank_d;
  logic                 valid_d;
  logic                 match, is_vic;
  logic                 first_hit, first_free, first_vic, sel;

  // Local compare against the broadcast page.
  assign match  = valid_q && (page_q == cmd_i.page);
  assign is_vic = valid_q && (rank_q == '0);

  assign first_hit  = match && !chain_i.hit;
  assign first_free = !valid_q && !chain_i.free;
  assign first_vic  = is_vic && !chain_i.vic;

  // Pass the search word on, claiming each slot if this is the first frame.
  always_comb begin
    chain_o = chain_i;
    if (first_hit) begin
      chain_o.hit      = 1'b1;
      chain_o.hit_idx  = idx_i;
      chain_o.hit_rank = rank_q;
    end
    if (first_free) begin
      chain_o.free     = 1'b1;
      chain_o.free_idx = idx_i;
    end
    if (first_vic) begin
      chain_o.vic      = 1'b1;
      chain_o.vic_idx  = idx_i;
      chain_o.vic_page = page_q;
    end
  end

  // Decide whether this frame is the one that takes the reference.
  always_comb begin
    unique case (cmd_i.op)
      OP_HIT:   sel = first_hit;
      OP_FILL:  sel = first_free;
      OP_EVICT: sel = first_vic;
      default:  sel = 1'b0;
    endcase
  end

  // Rank update: the chosen frame becomes most recent, frames above it move down.
  always_comb begin
    rank_d  = rank_q;
    valid_d = valid_q;
    if (cmd_i.en) begin
      if (sel) begin
        rank_d  = cmd_i.new_rank;
        valid_d = 1'b1;
      end else if (valid_q && (cmd_i.op != OP_FILL) && (rank_q > cmd_i.old_rank)) begin
        rank_d = rank_q - RANK_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
    end
  end

  // Page storage needs no reset: it is only read while valid.
  always_ff @(posedge clk_i) begin
    if (cmd_i.en && sel && (cmd_i.op != OP_HIT)) begin
      page_q <= cmd_i.page;
    end
  end

  assign stat_o = '{valid: valid_q, match: match, vic: is_vic};

endmodule

>>> rtl/lru_page_replacement_core.sv
// A reference word is captured at its accepting edge and resolved once any earlier
// result word is taken; the result word is registered at the resolving edge.
// No new reference is taken until the current one is resolved: the compare and rank
// update pass along the chain of frame cells runs once per reference, and
// a result word that is not taken holds the resolve step and the input.
// Reset clears all valid bits, ranks, the valid-frame count and the fault count
// at once; stored pages are not cleared and no clearing pass is needed.
module lru_page_replacement_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  lrup_in_if.sink    in_i,
  lrup_out_if.source out_o
);
  import lrup_pkg::*;

  logic                 busy_q;
  logic [PAGE_BITS-1:0] req_page_q;
  logic [CNT_W-1:0]     nvalid_q;
  logic [FAULT_W-1:0]   fault_q, fault_d;

  logic                 out_valid_q;
  logic                 hit_q, ev_valid_q;
  logic [OUT_IDX_W-1:0] frame_q;
  logic [IN_PAGE_W-1:0] ev_page_q;

  logic    accept, done, full;
  op_e     op;
  cmd_t    cmd;
  chain_t  chain_w [FRAMES+1];
  stat_t   stat_w  [FRAMES];
  logic [FRAMES-1:0] match_vec, vic_vec;
  logic [IDX_W-1:0]  sel_idx;

  assign in_i.ready = !busy_q;
  assign accept     = in_i.valid && !busy_q;
  assign done       = busy_q && (!out_valid_q || out_o.ready);
  assign full       = (nvalid_q == CNT_W'(FRAMES));

  // Row of frame cells, linked by the search chain.
  assign chain_w[0] = '0;
  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    lrup_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (IDX_W'(g)),
      .cmd_i   (cmd),
      .chain_i (chain_w[g]),
      .chain_o (chain_w[g+1]),
      .stat_o  (stat_w[g])
    );
    assign match_vec[g] = stat_w[g].match;
    assign vic_vec[g]   = stat_w[g].vic;
  end

  // Pick the operation from the end of the chain and build the command.
  always_comb begin
    if (chain_w[FRAMES].hit) begin
      op = OP_HIT;
    end else if (chain_w[FRAMES].free) begin
      op = OP_FILL;
    end else begin
      op = OP_EVICT;
    end
    cmd.en   = done;
    cmd.op   = op;
    cmd.page = req_page_q;
    unique case (op)
      OP_HIT: begin
        cmd.old_rank = chain_w[FRAMES].hit_rank;
        cmd.new_rank = RANK_W'(nvalid_q - CNT_W'(1));
        sel_idx      = chain_w[FRAMES].hit_idx;
      end
      OP_FILL: begin
        cmd.old_rank = '0;
        cmd.new_rank = RANK_W'(nvalid_q);
        sel_idx      = chain_w[FRAMES].free_idx;
      end
      OP_EVICT: begin
        cmd.old_rank = '0;
        cmd.new_rank = RANK_W'(FRAMES - 1);
        sel_idx      = chain_w[FRAMES].vic_idx;
      end
      default: begin
        cmd.old_rank = '0;
        cmd.new_rank = '0;
        sel_idx      = '0;
      end
    endcase
  end

  // Saturating fault count.
  always_comb begin
    fault_d = fault_q;
    if ((op != OP_HIT) && (fault_q != FAULT_MAX)) begin
      fault_d = fault_q + FAULT_W'(1);
    end
  end

  // Control state: busy flag, valid-frame count, fault count, result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      nvalid_q    <= '0;
      fault_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (done) begin
        busy_q <= 1'b0;
      end
      if (done) begin
        fault_q     <= fault_d;
        out_valid_q <= 1'b1;
        if (op == OP_FILL) begin
          nvalid_q <= nvalid_q + CNT_W'(1);
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request and result words.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_page_q <= to_page(in_i.vpn);
    end
    if (done) begin
      hit_q      <= (op == OP_HIT);
      frame_q    <= to_out_idx(sel_idx);
      ev_valid_q <= (op == OP_EVICT);
      ev_page_q  <= (op == OP_EVICT) ? from_page(chain_w[FRAMES].vic_page) : '0;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.hit           = hit_q;
  assign out_o.frame_index   = frame_q;
  assign out_o.evicted_valid = ev_valid_q;
  assign out_o.evicted_page  = ev_page_q;
  assign out_o.fault_total   = fault_q;

  // A page is never resident in two frames.
  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> $onehot0(match_vec))
    else $error("page matched in more than one frame");

  // With all frames valid exactly one frame holds the lowest rank.
  a_one_victim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && full) |-> $onehot(vic_vec))
    else $error("no unique least recently used frame");

  // The valid-frame count never passes the number of frames.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nvalid_q <= CNT_W'(FRAMES))
    else $error("valid-frame count out of range");

  // A miss with every frame valid reports an eviction.
  a_evict_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && (op == OP_EVICT)) |=> (out_valid_q && ev_valid_q))
    else $error("eviction not reported");

endmodule
